@@ hdl/direction_grid_point_generator_unit_defines.svh @@
// Assertion macros for the direction grid point generator
`ifndef DIRECTION_GRID_POINT_GENERATOR_UNIT_DEFINES_SVH
`define DIRECTION_GRID_POINT_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DGPG_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("dgpg: invariant violated");
`define DGPG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dgpg: implication violated");
`else
`define DGPG_ASSERT_ALWAYS(lbl, expr)
`define DGPG_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

@@ hdl/dgpg_pkg.sv @@
package dgpg_pkg;

    localparam int unsigned MAX_POINTS      = 4096;
    localparam int unsigned COORD_FRAC_BITS = 15;
    localparam int unsigned FRAC_SH         = 30 - COORD_FRAC_BITS;

    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam logic [31:0] INV_GOLD  = 32'd2654435769;

    // register index, taken from paddr[2]
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef enum logic [1:0] {
        GEO_SPHERE = 2'd0,
        GEO_HALF   = 2'd1,
        GEO_CIRCLE = 2'd2,
        GEO_ARC    = 2'd3
    } t_geo;

    // data riding along each pipeline step
    typedef struct packed {
        logic        err;
        t_geo        geo;
        logic        zneg;
        logic [30:0] zmag;
        logic [31:0] phase;
        logic [30:0] polar;
    } t_side;

    typedef struct packed {
        logic        vld;
        logic [13:0] rem;
        logic [13:0] dvs;
        logic [32:0] quo;
        t_side       side;
    } t_div_bus;

    typedef struct packed {
        logic        vld;
        logic [60:0] v;
        logic [61:0] res;
        t_side       side;
    } t_sqrt_bus;

    typedef struct packed {
        logic        vld;
        logic [30:0] a;
        logic [31:0] a2;
        logic [30:0] ts;
        logic [30:0] tc;
        t_side       side;
    } t_trig_bus;

endpackage

@@ hdl/dgpg_div_cell.sv @@
module dgpg_div_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  dgpg_pkg::t_div_bus  i_bus,
    output dgpg_pkg::t_div_bus  o_bus
);
    import dgpg_pkg::*;

    logic [14:0] x;
    logic [14:0] diff;
    logic        ge;
    t_div_bus    r_bus;
    t_div_bus    n_bus;

    // the leading cell produces the integer quotient bit without doubling
    always_comb begin
        x     = FIRST ? {1'b0, i_bus.rem} : {i_bus.rem, 1'b0};
        ge    = x >= {1'b0, i_bus.dvs};
        diff  = x - {1'b0, i_bus.dvs};
        n_bus = i_bus;
        n_bus.rem = ge ? diff[13:0] : x[13:0];
        n_bus.quo = {i_bus.quo[31:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.vld <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

@@ hdl/dgpg_sqrt_cell.sv @@
module dgpg_sqrt_cell #(
    parameter int unsigned K = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  dgpg_pkg::t_sqrt_bus  i_bus,
    output dgpg_pkg::t_sqrt_bus  o_bus
);
    import dgpg_pkg::*;

    localparam logic [61:0] BITV = 62'(1) << (2 * K);

    logic [61:0] sum;
    logic        ge;
    t_sqrt_bus   r_bus;
    t_sqrt_bus   n_bus;

    always_comb begin
        sum   = i_bus.res + BITV;
        ge    = {1'b0, i_bus.v} >= sum;
        n_bus = i_bus;
        n_bus.v   = ge ? (i_bus.v - sum[60:0]) : i_bus.v;
        n_bus.res = ge ? ((i_bus.res >> 1) + BITV) : (i_bus.res >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.vld <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

@@ hdl/dgpg_horner_cell.sv @@
module dgpg_horner_cell #(
    parameter int unsigned KS = 6,
    parameter int unsigned KC = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  dgpg_pkg::t_trig_bus  i_bus,
    output dgpg_pkg::t_trig_bus  o_bus
);
    import dgpg_pkg::*;

    // floor(2^32/K) underestimates p/K by less than one for p < 2^32
    localparam logic [31:0] RS = 32'((64'd1 << 32) / KS);
    localparam logic [31:0] RC = 32'((64'd1 << 32) / KC);
    localparam logic [31:0] ONE32 = 32'h4000_0000;

    typedef struct packed {
        logic        vld;
        logic [30:0] a;
        logic [31:0] a2;
        logic [31:0] ps;
        logic [31:0] pc;
        t_side       side;
    } t_hc_prod;

    typedef struct packed {
        t_hc_prod    p;
        logic [30:0] qs0;
        logic [30:0] qc0;
    } t_hc_quo;

    logic [62:0] mul_s;
    logic [62:0] mul_c;
    logic [63:0] rec_s;
    logic [63:0] rec_c;
    logic [31:0] rem_s;
    logic [31:0] rem_c;
    logic [31:0] qs;
    logic [31:0] qc;
    t_hc_prod    r_prod;
    t_hc_prod    n_prod;
    t_hc_quo     r_quo;
    t_hc_quo     n_quo;
    t_trig_bus   r_out;
    t_trig_bus   n_out;

    always_comb begin
        mul_s       = 63'(i_bus.a2) * 63'(i_bus.ts);
        mul_c       = 63'(i_bus.a2) * 63'(i_bus.tc);
        n_prod.vld  = i_bus.vld;
        n_prod.a    = i_bus.a;
        n_prod.a2   = i_bus.a2;
        n_prod.side = i_bus.side;
        n_prod.ps   = mul_s[61:30];
        n_prod.pc   = mul_c[61:30];
    end

    always_comb begin
        rec_s     = 64'(r_prod.ps) * 64'(RS);
        rec_c     = 64'(r_prod.pc) * 64'(RC);
        n_quo.p   = r_prod;
        n_quo.qs0 = rec_s[62:32];
        n_quo.qc0 = rec_c[62:32];
    end

    // one correction step finishes the constant division
    always_comb begin
        rem_s      = r_quo.p.ps - 32'({1'b0, r_quo.qs0} * 32'(KS));
        rem_c      = r_quo.p.pc - 32'({1'b0, r_quo.qc0} * 32'(KC));
        qs         = {1'b0, r_quo.qs0} + 32'(rem_s >= 32'(KS));
        qc         = {1'b0, r_quo.qc0} + 32'(rem_c >= 32'(KC));
        n_out.vld  = r_quo.p.vld;
        n_out.a    = r_quo.p.a;
        n_out.a2   = r_quo.p.a2;
        n_out.side = r_quo.p.side;
        n_out.ts   = 31'(ONE32 - qs);
        n_out.tc   = 31'(ONE32 - qc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.vld  <= 1'b0;
            r_quo.p.vld <= 1'b0;
            r_out.vld   <= 1'b0;
        end else if (i_en) begin
            r_prod <= n_prod;
            r_quo  <= n_quo;
            r_out  <= n_out;
        end
    end

    assign o_bus = r_out;

endmodule

@@ hdl/direction_grid_point_generator_unit.sv @@
// Gives the unit direction (x, y, z in Q1.15) of grid point point_index for a Fibonacci
// sphere, half sphere, circle or arc of point_count points, set over the register port
// (offset 0: geometry mode, offset 4: point count). One item is accepted per clock while
// the skid stage is empty; each item passes 91 register stages, most of them in the
// 33-cell quotient chain, the 31-cell square-root chain and the six three-stage Horner
// cells for sine and cosine.
// An output register with a skid stage keeps input tready high while one result waits.
// Out-of-range indexes and an arc of one point give zero coordinates with tuser set.
`include "direction_grid_point_generator_unit_defines.svh"
module direction_grid_point_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] point_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z
    output logic        m_axis_tuser    // [0] index_error
);
    import dgpg_pkg::*;

    localparam int unsigned DIV_CELLS  = 33;
    localparam int unsigned SQRT_CELLS = 31;
    localparam int unsigned HC_CELLS   = 6;

    typedef struct packed {
        logic  vld;
        t_side side;
    } t_zst;

    typedef struct packed {
        logic        vld;
        logic [30:0] s;
        logic [31:0] c_pre;
        t_side       side;
    } t_f1;

    typedef struct packed {
        logic        vld;
        logic [30:0] cmag;
        logic [30:0] smag;
        logic        cneg;
        logic        sneg;
        t_side       side;
    } t_f2;

    typedef struct packed {
        logic        vld;
        logic [31:0] xm;
        logic [31:0] ym;
        logic        cneg;
        logic        sneg;
        t_side       side;
    } t_f3;

    typedef struct packed {
        logic        err;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_out;

    function automatic logic [15:0] f_to_out(input logic [31:0] mag, input logic neg);
        logic [32:0] rnd;
        logic [17:0] m;
        logic [15:0] res;
        rnd = {1'b0, mag} + (33'(1) << (FRAC_SH - 1));
        m   = 18'(rnd >> FRAC_SH);
        if (neg) begin
            res = (m > 18'd32768) ? 16'h8000 : 16'(18'd0 - m);
        end else begin
            res = (m > 18'd32767) ? 16'h7FFF : m[15:0];
        end
        return res;
    endfunction

    // configuration
    t_geo        r_mode;
    logic [12:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= GEO_SPHERE;
            r_count <= 13'd1024;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_MODE:  r_mode  <= t_geo'(pwdata[1:0]);
                REG_COUNT: r_count <= pwdata[12:0];
                default:   r_count <= r_count;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COUNT) ? {19'd0, r_count} : {30'd0, r_mode};

    // pipeline control
    logic en;
    logic r_skid_vld;
    logic r_out_vld;
    t_out r_skid;
    t_out r_out;

    assign en            = !r_skid_vld;
    assign s_axis_tready = en;

    // entry stage
    logic [12:0] n_eff;
    logic [11:0] idx;
    logic [43:0] gold;
    t_div_bus    n_s0;
    t_div_bus    r_s0;

    always_comb begin
        idx   = s_axis_tdata[11:0];
        n_eff = (r_count > 13'(MAX_POINTS)) ? 13'(MAX_POINTS) : r_count;
        gold  = 44'(idx) * 44'(INV_GOLD);
        n_s0.vld = s_axis_tvalid;
        n_s0.quo = '0;
        n_s0.side.err   = ({1'b0, idx} >= n_eff) || (r_mode == GEO_ARC && n_eff == 13'd1);
        n_s0.side.geo   = r_mode;
        n_s0.side.zneg  = 1'b0;
        n_s0.side.zmag  = '0;
        n_s0.side.phase = gold[31:0];
        n_s0.side.polar = '0;
        unique case (r_mode)
            GEO_SPHERE: begin
                n_s0.dvs = {1'b0, n_eff};
                n_s0.rem = {1'b0, idx, 1'b1};
            end
            GEO_HALF: begin
                n_s0.dvs = {n_eff, 1'b0};
                n_s0.rem = {1'b0, idx, 1'b1};
            end
            GEO_CIRCLE: begin
                n_s0.dvs = {1'b0, n_eff};
                n_s0.rem = {2'b0, idx};
            end
            GEO_ARC: begin
                n_s0.dvs = {1'b0, n_eff - 13'd1};
                n_s0.rem = {2'b0, idx};
            end
            default: begin
                n_s0.dvs = {1'b0, n_eff};
                n_s0.rem = {2'b0, idx};
            end
        endcase
        // zero divisor only occurs on error items
        if (n_s0.dvs == 14'd0) begin
            n_s0.dvs = 14'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
        end
    end

    // quotient chain: floor(A * 2^32 / D)
    t_div_bus w_div [0:DIV_CELLS];
    assign w_div[0] = r_s0;

    for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
        dgpg_div_cell #(.FIRST(j == 0)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (w_div[j]),
            .o_bus   (w_div[j+1])
        );
    end

    // z and phase
    logic [30:0] qz;
    t_zst        n_z;
    t_zst        r_z;

    always_comb begin
        qz       = w_div[DIV_CELLS].quo[32:2];
        n_z.vld  = w_div[DIV_CELLS].vld;
        n_z.side = w_div[DIV_CELLS].side;
        if (n_z.side.geo == GEO_SPHERE || n_z.side.geo == GEO_HALF) begin
            n_z.side.zneg = qz > ONE_Q30;
            n_z.side.zmag = (qz > ONE_Q30) ? (qz - ONE_Q30) : (ONE_Q30 - qz);
        end else begin
            n_z.side.zneg  = 1'b0;
            n_z.side.zmag  = '0;
            n_z.side.phase = w_div[DIV_CELLS].quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z.vld <= 1'b0;
        end else if (en) begin
            r_z <= n_z;
        end
    end

    // radicand 1 - z^2
    logic [61:0] zsq;
    t_sqrt_bus   n_v;
    t_sqrt_bus   r_v;

    always_comb begin
        zsq      = 62'(r_z.side.zmag) * 62'(r_z.side.zmag);
        n_v.vld  = r_z.vld;
        n_v.side = r_z.side;
        n_v.v    = (61'd1 << 60) - zsq[60:0];
        n_v.res  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v.vld <= 1'b0;
        end else if (en) begin
            r_v <= n_v;
        end
    end

    t_sqrt_bus w_sq [0:SQRT_CELLS];
    assign w_sq[0] = r_v;

    for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
        dgpg_sqrt_cell #(.K(SQRT_CELLS - 1 - j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (w_sq[j]),
            .o_bus   (w_sq[j+1])
        );
    end

    // angle within the quadrant, then its square
    logic [61:0] prod_a;
    logic [61:0] prod_a2;
    t_trig_bus   n_t1;
    t_trig_bus   r_t1;
    t_trig_bus   n_t2;
    t_trig_bus   r_t2;

    always_comb begin
        prod_a            = 62'(w_sq[SQRT_CELLS].side.phase[29:0]) * 62'(PI_Q30);
        n_t1.vld          = w_sq[SQRT_CELLS].vld;
        n_t1.side         = w_sq[SQRT_CELLS].side;
        n_t1.side.polar   = w_sq[SQRT_CELLS].res[30:0];
        n_t1.a            = prod_a[61:31];
        n_t1.a2           = '0;
        n_t1.ts           = ONE_Q30;
        n_t1.tc           = ONE_Q30;
    end

    always_comb begin
        prod_a2 = 62'(r_t1.a) * 62'(r_t1.a);
        n_t2    = r_t1;
        n_t2.a2 = prod_a2[61:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.vld <= 1'b0;
            r_t2.vld <= 1'b0;
        end else if (en) begin
            r_t1 <= n_t1;
            r_t2 <= n_t2;
        end
    end

    t_trig_bus w_hc [0:HC_CELLS];
    assign w_hc[0] = r_t2;

    for (genvar j = 0; j < HC_CELLS; j++) begin : g_hc
        localparam int unsigned KSJ = (13 - 2 * j) * (12 - 2 * j);
        localparam int unsigned KCJ = (14 - 2 * j) * (13 - 2 * j);
        dgpg_horner_cell #(.KS(KSJ), .KC(KCJ)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (w_hc[j]),
            .o_bus   (w_hc[j+1])
        );
    end

    // final sine and cosine terms
    logic [61:0] prod_s;
    logic [62:0] prod_c;
    t_f1         n_f1;
    t_f1         r_f1;

    always_comb begin
        prod_s     = 62'(w_hc[HC_CELLS].a) * 62'(w_hc[HC_CELLS].ts);
        prod_c     = 63'(w_hc[HC_CELLS].a2) * 63'(w_hc[HC_CELLS].tc);
        n_f1.vld   = w_hc[HC_CELLS].vld;
        n_f1.side  = w_hc[HC_CELLS].side;
        n_f1.s     = prod_s[60:30];
        n_f1.c_pre = prod_c[61:30];
    end

    // cosine clamp and quadrant mapping
    logic [30:0] half_c;
    logic [30:0] cval;
    t_f2         n_f2;
    t_f2         r_f2;

    always_comb begin
        half_c    = r_f1.c_pre[31:1];
        cval      = (half_c > ONE_Q30) ? 31'd0 : (ONE_Q30 - half_c);
        n_f2.vld  = r_f1.vld;
        n_f2.side = r_f1.side;
        unique case (r_f1.side.phase[31:30])
            2'd0: begin
                n_f2.cmag = cval;   n_f2.cneg = 1'b0;
                n_f2.smag = r_f1.s; n_f2.sneg = 1'b0;
            end
            2'd1: begin
                n_f2.cmag = r_f1.s; n_f2.cneg = 1'b1;
                n_f2.smag = cval;   n_f2.sneg = 1'b0;
            end
            2'd2: begin
                n_f2.cmag = cval;   n_f2.cneg = 1'b1;
                n_f2.smag = r_f1.s; n_f2.sneg = 1'b1;
            end
            default: begin
                n_f2.cmag = r_f1.s; n_f2.cneg = 1'b0;
                n_f2.smag = cval;   n_f2.sneg = 1'b1;
            end
        endcase
    end

    // scale by sin(polar)
    logic [61:0] prod_x;
    logic [61:0] prod_y;
    t_f3         n_f3;
    t_f3         r_f3;

    always_comb begin
        prod_x    = 62'(r_f2.cmag) * 62'(r_f2.side.polar);
        prod_y    = 62'(r_f2.smag) * 62'(r_f2.side.polar);
        n_f3.vld  = r_f2.vld;
        n_f3.side = r_f2.side;
        n_f3.cneg = r_f2.cneg;
        n_f3.sneg = r_f2.sneg;
        n_f3.xm   = prod_x[61:30];
        n_f3.ym   = prod_y[61:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1.vld <= 1'b0;
            r_f2.vld <= 1'b0;
            r_f3.vld <= 1'b0;
        end else if (en) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
            r_f3 <= n_f3;
        end
    end

    // output formatting
    t_out fmt;

    always_comb begin
        fmt.err = r_f3.side.err;
        if (r_f3.side.err) begin
            fmt.x = '0;
            fmt.y = '0;
            fmt.z = '0;
        end else begin
            fmt.x = f_to_out(r_f3.xm, r_f3.cneg);
            fmt.y = f_to_out(r_f3.ym, r_f3.sneg);
            fmt.z = f_to_out(32'(r_f3.side.zmag), r_f3.side.zneg);
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && !m_axis_tready) begin
            if (en && r_f3.vld) begin
                r_skid_vld <= 1'b1;
                r_skid     <= fmt;
            end
        end else if (r_skid_vld) begin
            r_out      <= r_skid;
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld <= r_f3.vld;
            r_out     <= fmt;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.z, r_out.y, r_out.x};
    assign m_axis_tuser  = r_out.err;

    `DGPG_ASSERT_IMPL(a_skid_implies_out, r_skid_vld, r_out_vld)
    `DGPG_ASSERT_IMPL(a_err_zero, r_out_vld && r_out.err, {r_out.x, r_out.y, r_out.z} == 48'd0)
    `DGPG_ASSERT_IMPL(a_skid_on_stall, $rose(r_skid_vld), $past(r_out_vld && !m_axis_tready))

endmodule

@@ tb/sv/direction_grid_point_generator_unit_test.sv @@
`timescale 1ns / 100ps
module direction_grid_point_generator_unit_test;
    import dgpg_pkg::*;

    typedef struct {
        logic [11:0] idx;
        logic        hold;   // wait for all results before sending
    } t_pending;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        err;
    } t_coord;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [11:0] point_index
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;    // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z
    logic        m_axis_tuser;    // [0] index_error

    t_pending    pending_q[$];
    t_coord      coord_q[$];
    t_geo        geo_mode;
    logic [12:0] pt_count;
    int          mismatches;
    int          send_gap;
    int          recv_gap;
    logic        calm;            // no idling on either side

    direction_grid_point_generator_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Q30 sine/cosine magnitudes of a 32-bit phase, Taylor series by Horner
    function automatic void phase_trig(input logic [31:0] phase,
                                       output logic [63:0] smag, output logic sneg,
                                       output logic [63:0] cmag, output logic cneg);
        logic [63:0] one;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] c;
        logic signed [63:0] cs;
        one = 64'd1 << 30;
        r = {34'd0, phase[29:0]};
        a = (r * 64'd3373259426) >> 31;
        a2 = (a * a) >> 30;
        t = one;
        for (int k = 13; k >= 3; k -= 2)
            t = one - ((a2 * t) >> 30) / 64'(k * (k - 1));
        s = (a * t) >> 30;
        t = one;
        for (int k = 14; k >= 4; k -= 2)
            t = one - ((a2 * t) >> 30) / 64'(k * (k - 1));
        cs = $signed(one) - $signed(((a2 * t) >> 30) / 64'd2);
        c = (cs < 0) ? 64'd0 : cs;
        case (phase[31:30])
            2'd0: begin cmag = c; cneg = 0; smag = s; sneg = 0; end
            2'd1: begin cmag = s; cneg = 1; smag = c; sneg = 0; end
            2'd2: begin cmag = c; cneg = 1; smag = s; sneg = 1; end
            default: begin cmag = s; cneg = 0; smag = c; sneg = 1; end
        endcase
    endfunction

    function automatic logic [15:0] q15_round(logic [63:0] mag, logic neg);
        logic [63:0] m;
        m = (mag + (64'd1 << 14)) >> 15;
        if (neg) begin
            if (m > 32768) m = 32768;
            return 16'(-m);
        end
        if (m > 32767) m = 32767;
        return m[15:0];
    endfunction

    function automatic t_coord grid_point(logic [11:0] idx);
        t_coord      res;
        logic [63:0] i;
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] zmag;
        logic [63:0] polar;
        logic [63:0] smag;
        logic [63:0] cmag;
        logic        sneg;
        logic        cneg;
        logic        zneg;
        logic signed [63:0] z;
        logic [31:0] phase;
        i = idx;
        n = (pt_count > MAX_POINTS) ? 64'(MAX_POINTS) : 64'(pt_count);
        res = '{x: 0, y: 0, z: 0, err: 1};
        if (i >= n || (geo_mode == GEO_ARC && n == 1)) return res;
        zneg = 0;
        zmag = 0;
        polar = 64'd1 << 30;
        if (geo_mode == GEO_SPHERE || geo_mode == GEO_HALF) begin
            m = (geo_mode == GEO_SPHERE) ? n : 2 * n;
            q = ((2 * i + 1) << 30) / m;
            z = $signed(64'd1 << 30) - $signed(q);
            zneg = z < 0;
            zmag = zneg ? -z : z;
            polar = int_sqrt((64'd1 << 60) - zmag * zmag);
            phase = 32'(i * 64'd2654435769);
        end else if (geo_mode == GEO_CIRCLE) begin
            phase = 32'((i << 32) / n);
        end else begin
            phase = 32'((i << 32) / (n - 1));
        end
        phase_trig(phase, smag, sneg, cmag, cneg);
        res.x = q15_round((cmag * polar) >> 30, cneg);
        res.y = q15_round((smag * polar) >> 30, sneg);
        res.z = q15_round(zmag, zneg);
        res.err = 0;
        return res;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // sender
    always @(posedge i_clk) begin
        logic     nv;
        t_pending p;
        nv = s_axis_tvalid;
        if (!i_rst_n) begin
            nv = 0;
            send_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                coord_q.push_back(grid_point(s_axis_tdata[11:0]));
                nv = 0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_q.size() > 0 &&
                             (!pending_q[0].hold || coord_q.size() == 0)) begin
                    p = pending_q.pop_front();
                    nv = 1;
                    s_axis_tdata <= {4'd0, p.idx};
                    send_gap <= calm ? 0 : $urandom_range(0, 5);
                end
            end
        end
        s_axis_tvalid <= nv;
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_coord exp_c;
        int     w;
        if (!i_rst_n) begin
            m_axis_tready <= 0;
            recv_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (coord_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected item %h", m_axis_tdata);
                end else begin
                    exp_c = coord_q.pop_front();
                    if (exp_c.x !== m_axis_tdata[15:0] || exp_c.y !== m_axis_tdata[31:16] ||
                        exp_c.z !== m_axis_tdata[47:32] || exp_c.err !== m_axis_tuser) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("exp x=%h y=%h z=%h err=%b  got x=%h y=%h z=%h err=%b",
                                     exp_c.x, exp_c.y, exp_c.z, exp_c.err,
                                     m_axis_tdata[15:0], m_axis_tdata[31:16],
                                     m_axis_tdata[47:32], m_axis_tuser);
                    end
                end
                w = calm ? 0 : $urandom_range(0, 5);
                recv_gap <= w;
                m_axis_tready <= (w == 0);
            end else if (!m_axis_tready) begin
                if (recv_gap <= 1) m_axis_tready <= 1;
                recv_gap <= recv_gap - 1;
            end
        end
    end

    task automatic reg_write(logic reg_idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {reg_idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (reg_idx == REG_MODE) geo_mode = t_geo'(val[1:0]);
        else pt_count = val[12:0];
    endtask

    // sampled at the falling edge so that the clocked blocks have settled
    task automatic wait_idle();
        while (pending_q.size() > 0 || coord_q.size() > 0 || s_axis_tvalid)
            @(negedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_grid(t_geo g, logic [12:0] n);
        wait_idle();
        reg_write(REG_MODE, {30'd0, g});
        reg_write(REG_COUNT, {19'd0, n});
    endtask

    task automatic send_point(logic [11:0] idx, logic hold);
        pending_q.push_back('{idx: idx, hold: hold});
    endtask

    task automatic send_edges();
        int n;
        n = (pt_count > MAX_POINTS) ? MAX_POINTS : pt_count;
        send_point(0, 0);
        send_point(12'(n - 1), 0);
        send_point(12'(n), 0);
        send_point(12'hFFF, 0);
    endtask

    initial begin
        int       n;
        int       cnt;
        t_geo     g;
        logic [12:0] nc;
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0;
        m_axis_tready = 0;
        mismatches = 0;
        calm = 0;
        send_gap = 0;
        recv_gap = 0;
        geo_mode = GEO_SPHERE;
        pt_count = 13'd1024;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // reset configuration, then the corner grids
        send_edges();
        send_point(12'd1, 0);
        set_grid(GEO_SPHERE, 13'd1);    send_edges();
        set_grid(GEO_HALF, 13'd4096);   send_edges();
        set_grid(GEO_CIRCLE, 13'd1);    send_edges();
        set_grid(GEO_ARC, 13'd1);       send_edges();
        set_grid(GEO_ARC, 13'd2);       send_edges();
        set_grid(GEO_SPHERE, 13'd0);    send_edges();
        set_grid(GEO_CIRCLE, 13'h1FFF); send_edges();

        for (int ph = 0; ph < 12; ph++) begin
            g = t_geo'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: nc = 13'd4096;
                1: nc = 13'($urandom_range(4097, 8191));
                2: nc = 13'($urandom_range(1, 8));
                default: nc = 13'($urandom_range(1, 4096));
            endcase
            set_grid(g, nc);
            calm = (ph % 4 == 3);
            n = (nc > MAX_POINTS) ? MAX_POINTS : nc;
            cnt = $urandom_range(38, 48);
            for (int k = 0; k < cnt; k++) begin
                if ($urandom_range(0, 9) < 8)
                    send_point(12'($urandom_range(0, n - 1)), k == cnt / 2);
                else
                    send_point(12'($urandom_range(0, 4095)), k == cnt / 2);
            end
        end

        wait_idle();
        if (mismatches == 0 && coord_q.size() == 0) begin
            $display("direction_grid_point_generator_unit: match");
        end else begin
            $display("direction_grid_point_generator_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("direction_grid_point_generator_unit: mismatch");
        $finish;
    end
endmodule
